/* src/fatchs_pkg.sv */
// ----------------------------------------------------------------------------
// fatchs_pkg
// Shared types and constants for the cluster to CHS request unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fatchs_pkg;

    localparam int BLOCK_W = 16;
    localparam int SPT_W   = 6;
    localparam int HC_W    = 8;
    localparam int SPC_W   = 7;
    localparam int CNT_W   = 7;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;

    typedef enum logic [IDX_W-1:0] {
        CFG_SECTORS_PER_TRACK   = 3'd0,
        CFG_HEAD_COUNT          = 3'd1,
        CFG_SECTORS_PER_CLUSTER = 3'd2,
        CFG_DATA_AREA_BASE      = 3'd3,
        CFG_TOTAL_SECTOR_COUNT  = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_DIV1,
        ST_DIV2
    } fatchs_state_t;

    typedef struct packed {
        logic               start;
        logic [BLOCK_W-1:0] dividend;
        logic [HC_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [BLOCK_W-1:0] quotient;
        logic [HC_W-1:0]    remainder;
    } div_stat_t;

endpackage

`default_nettype wire

/* src/fatchs_div.sv */
// ----------------------------------------------------------------------------
// fatchs_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fatchs_div (
    input  wire                   clk,
    input  wire                   rst_n,
    input  fatchs_pkg::div_req_t  req,
    output fatchs_pkg::div_stat_t stat
);
    import fatchs_pkg::*;

    localparam int STEP_W = $clog2(BLOCK_W);

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [BLOCK_W-1:0] q_reg;
    logic [HC_W-1:0]    rem_reg;
    logic [HC_W-1:0]    dvs_reg;

    logic [HC_W:0]      shifted;
    logic               ge;
    logic [HC_W-1:0]    rem_next;
    logic [HC_W:0]      diff;

    always_comb
    begin
        shifted  = {rem_reg, q_reg[BLOCK_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        ge       = (shifted >= {1'b0, dvs_reg});
        rem_next = ge ? diff[HC_W-1:0] : shifted[HC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(BLOCK_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[BLOCK_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign stat.done      = done_reg;
    assign stat.quotient  = q_reg;
    assign stat.remainder = rem_reg;

endmodule

`default_nettype wire

/* src/fat_cluster_to_chs_requests_unit.sv */
// ----------------------------------------------------------------------------
// fat_cluster_to_chs_requests_unit
// Turns cluster reads and raw block runs into a stream of CHS addresses.
//
// channel   signals                                      transfer
// --------  -------------------------------------------  -------------------
// request   req_type cluster_number start_block           start && !busy
//           block_count
// result    cylinder head sector status last              result_valid
// config    cfg_index cfg_data                            cfg_write
//
// Cluster requests pass through the shift-add multiplier first.
// Each sector takes one range check plus two 16-bit passes
// through the shared bit-serial divider (block / spt, then / heads).
// An out-of-range block or a zero count ends the run in the check state.
// busy is high from the transfer until the run ends; results cannot stall.
// Reset loads the default geometry and leaves the unit idle.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_cluster_to_chs_requests_unit #(
    parameter int MAX_RUN = 64
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    output logic                           busy,
    input  wire                            req_type,
    input  wire  [11:0]                    cluster_number,
    input  wire  [fatchs_pkg::BLOCK_W-1:0] start_block,
    input  wire  [fatchs_pkg::CNT_W-1:0]   block_count,
    output logic                           result_valid,
    output logic [fatchs_pkg::BLOCK_W-1:0] cylinder,
    output logic [fatchs_pkg::HC_W-1:0]    head,
    output logic [fatchs_pkg::SPT_W-1:0]   sector,
    output logic                           status,
    output logic                           last,
    input  wire                            cfg_write,
    input  wire  [fatchs_pkg::IDX_W-1:0]   cfg_index,
    input  wire  [fatchs_pkg::CFG_W-1:0]   cfg_data
);
    import fatchs_pkg::*;

    localparam int MUL_W = $clog2(SPC_W);

    fatchs_state_t      state_reg, state_next;

    logic [SPT_W-1:0]   spt_reg;
    logic [HC_W-1:0]    hc_reg;
    logic [SPC_W-1:0]   spc_reg;
    logic [BLOCK_W-1:0] base_reg;
    logic [BLOCK_W-1:0] total_reg;

    logic [BLOCK_W:0]   block_reg;
    logic [CNT_W-1:0]   remain_reg;
    logic [BLOCK_W-1:0] mcand_reg;
    logic [SPC_W-1:0]   mplier_reg;
    logic [MUL_W-1:0]   mul_step_reg;
    logic [SPT_W-1:0]   s_reg;

    logic               valid_reg;
    logic [BLOCK_W-1:0] cyl_reg;
    logic [HC_W-1:0]    head_reg;
    logic [SPT_W-1:0]   sector_reg;
    logic               status_reg;
    logic               last_reg;

    logic               accept;
    logic               mul_done;
    logic               out_of_range;
    logic               emit_err;
    logic               emit_ok;
    logic [SPT_W-1:0]   spt_eff;
    logic [HC_W-1:0]    hc_eff;
    logic [CNT_W-1:0]   req_count;
    logic [CNT_W-1:0]   sat_count;
    div_req_t           div_req;
    div_stat_t          div_stat;

    assign accept       = start && (state_reg == ST_IDLE);
    assign busy         = (state_reg != ST_IDLE);
    assign mul_done     = (mul_step_reg == MUL_W'(SPC_W - 1));
    assign out_of_range = (block_reg >= {1'b0, total_reg});
    assign spt_eff      = (spt_reg == '0) ? SPT_W'(1) : spt_reg;
    assign hc_eff       = (hc_reg == '0) ? HC_W'(1) : hc_reg;
    assign req_count    = req_type ? block_count : spc_reg;
    assign sat_count    = (req_count > CNT_W'(MAX_RUN)) ? CNT_W'(MAX_RUN) : req_count;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = req_type ? ST_CHECK : ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_done)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (remain_reg == '0 || out_of_range)
                    state_next = ST_IDLE;
                else
                    state_next = ST_DIV1;
            end
            ST_DIV1:
            begin
                if (div_stat.done)
                    state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                if (div_stat.done)
                    state_next = ST_CHECK;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = block_reg[BLOCK_W-1:0];
        div_req.divisor  = {{(HC_W-SPT_W){1'b0}}, spt_eff};
        emit_err         = 1'b0;
        emit_ok          = 1'b0;
        unique case (state_reg)
            ST_CHECK:
            begin
                if (remain_reg != '0)
                begin
                    emit_err      = out_of_range;
                    div_req.start = !out_of_range;
                end
            end
            ST_DIV1:
            begin
                div_req.start    = div_stat.done;
                div_req.dividend = div_stat.quotient;
                div_req.divisor  = hc_eff;
            end
            ST_DIV2:
            begin
                emit_ok = div_stat.done;
            end
            default:
            begin
            end
        endcase
    end

    fatchs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            spt_reg   <= SPT_W'(18);
            hc_reg    <= HC_W'(2);
            spc_reg   <= SPC_W'(1);
            base_reg  <= BLOCK_W'(33);
            total_reg <= BLOCK_W'(2880);
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= emit_err || emit_ok;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_SECTORS_PER_TRACK:   spt_reg   <= cfg_data[SPT_W-1:0];
                    CFG_HEAD_COUNT:          hc_reg    <= cfg_data[HC_W-1:0];
                    CFG_SECTORS_PER_CLUSTER: spc_reg   <= cfg_data[SPC_W-1:0];
                    CFG_DATA_AREA_BASE:      base_reg  <= cfg_data[BLOCK_W-1:0];
                    CFG_TOTAL_SECTOR_COUNT:  total_reg <= cfg_data[BLOCK_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            remain_reg   <= sat_count;
            mul_step_reg <= '0;
            if (req_type)
                block_reg <= {1'b0, start_block};
            else
                block_reg <= {1'b0, base_reg};
            mcand_reg  <= {4'd0, cluster_number} - BLOCK_W'(2);
            mplier_reg <= spc_reg;
        end
        else if (state_reg == ST_MUL)
        begin
            if (mplier_reg[0])
                block_reg <= {1'b0, block_reg[BLOCK_W-1:0] + mcand_reg};
            mcand_reg    <= {mcand_reg[BLOCK_W-2:0], 1'b0};
            mplier_reg   <= {1'b0, mplier_reg[SPC_W-1:1]};
            mul_step_reg <= mul_step_reg + 1'b1;
        end
        else if (emit_ok)
        begin
            block_reg  <= block_reg + 1'b1;
            remain_reg <= remain_reg - 1'b1;
        end

        if (state_reg == ST_DIV1 && div_stat.done)
            s_reg <= div_stat.remainder[SPT_W-1:0];

        if (emit_err)
        begin
            cyl_reg    <= '0;
            head_reg   <= '0;
            sector_reg <= '0;
            status_reg <= 1'b1;
            last_reg   <= 1'b1;
        end
        else if (emit_ok)
        begin
            cyl_reg    <= div_stat.quotient;
            head_reg   <= div_stat.remainder;
            sector_reg <= s_reg + 1'b1;
            status_reg <= 1'b0;
            last_reg   <= (remain_reg == CNT_W'(1));
        end
    end

    assign result_valid = valid_reg;
    assign cylinder     = cyl_reg;
    assign head         = head_reg;
    assign sector       = sector_reg;
    assign status       = status_reg;
    assign last         = last_reg;

    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status |-> last && sector == '0 && cylinder == '0 && head == '0)
        else $error("error result with nonzero fields");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV1 || state_reg == ST_DIV2))
        else $error("divider finished outside a divide state");

    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request transfer");

    a_no_result_idle_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> !result_valid)
        else $error("result during cluster multiply");

endmodule

`default_nettype wire
